// ===== hdl/aia_pkg.sv =====
// shared types and constants of the association id allocator
package aia_pkg;

	localparam int unsigned ID_W     = 11;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned BIT_W    = 5;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BAD_ID = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
	} aia_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free;
	} aia_sts_t;

endpackage

// ===== hdl/aia_if.sv =====
// request and response channel interfaces
interface aia_req_if;
	import aia_pkg::*;
	logic         valid;
	logic         ready;
	kind_t        kind;
	logic [ID_W-1:0] free_id;

	modport source (output valid, kind, free_id, input ready);
	modport sink (input valid, kind, free_id, output ready);
endinterface

interface aia_rsp_if;
	import aia_pkg::*;
	logic         valid;
	logic         ready;
	logic [ID_W-1:0] given_id;
	status_t      status;

	modport source (output valid, given_id, status, input ready);
	modport sink (input valid, given_id, status, output ready);
endinterface

// ===== hdl/aia_ctrl.sv =====
// sequencing state machine of the allocator
module aia_ctrl
	import aia_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  aia_sts_t sts,
	output aia_cmd_t cmd
);

	typedef enum logic [2:0] {
		FSM_IDLE   = 3'b001,
		FSM_LOOK   = 3'b010,
		FSM_UPDATE = 3'b100
	} fsm_t;

	fsm_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.lookup  = 1'b0;
		cmd.commit  = 1'b0;
		req_ready   = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = FSM_LOOK;
				end
			end
			FSM_LOOK: begin
				cmd.lookup = 1'b1;
				state_d    = FSM_UPDATE;
			end
			FSM_UPDATE: begin
				if (sts.slot_free) begin
					cmd.commit = 1'b1;
					state_d    = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/aia_dp.sv =====
// bitmap memory, full summary, bit search and result register
module aia_dp
	import aia_pkg::*;
#(
	parameter int unsigned MAP_WORDS = 64,
	parameter int unsigned MAX_ID    = 2007
) (
	input  logic            clk,
	input  logic            arst_n,
	input  aia_cmd_t        cmd,
	output aia_sts_t        sts,
	input  kind_t           req_kind,
	input  logic [ID_W-1:0] req_free_id,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output logic [ID_W-1:0] rsp_given_id,
	output status_t         rsp_status
);

	localparam int unsigned WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	logic [WORD_W-1:0]    mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] full_q;
	logic [MAP_WORDS-1:0] vld_q;

	kind_t           kind_q;
	logic [ID_W-1:0] id_q;

	logic [WW-1:0]     addr_s1;
	logic              none_s1;
	logic              vld_s1;
	logic [WORD_W-1:0] rd_word_s1;

	logic              out_valid_q;
	logic [ID_W-1:0]   given_id_q;
	status_t           status_q;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= req_kind;
			id_q   <= req_free_id;
		end
	end

	// first word that is not full
	logic [WW-1:0] first_w;
	always_comb begin
		first_w = '0;
		for (int i = MAP_WORDS - 1; i >= 0; i--) begin
			if (!full_q[i]) begin
				first_w = WW'(i);
			end
		end
	end

	// word and bit of the id being freed
	logic [ID_W-1:0] idm1;
	logic [5:0]      free_w;
	logic            free_bad;
	assign idm1     = id_q - ID_W'(1);
	assign free_w   = idm1[ID_W-1:BIT_W];
	assign free_bad = (id_q == '0) || ({1'b0, id_q} > 12'(MAX_ID))
		|| ({1'b0, free_w} >= 7'(MAP_WORDS));

	logic [WW-1:0] look_addr;
	logic          look_none;
	always_comb begin
		if (kind_q == KIND_ALLOC) begin
			look_addr = first_w;
			look_none = &full_q;
		end else begin
			look_addr = free_w[WW-1:0];
			look_none = free_bad;
		end
	end

	// registered memory read
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			addr_s1    <= look_addr;
			none_s1    <= look_none;
			vld_s1     <= vld_q[look_addr];
			rd_word_s1 <= mem[look_addr];
		end
	end

	// lowest clear bit of the word read
	logic [WORD_W-1:0] word;
	logic [BIT_W-1:0]  low_b;
	assign word = vld_s1 ? rd_word_s1 : '0;
	always_comb begin
		low_b = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!word[i]) begin
				low_b = BIT_W'(i);
			end
		end
	end

	// new word and result
	logic [ID_W:0]     cand;
	logic              alloc_ok;
	logic              do_write;
	logic [WORD_W-1:0] new_word;
	logic [ID_W-1:0]   res_id;
	status_t           res_st;
	assign cand = (ID_W + 1)'({addr_s1, low_b}) + (ID_W + 1)'(1);
	assign alloc_ok = !none_s1 && (cand <= 12'(MAX_ID));
	always_comb begin
		if (kind_q == KIND_ALLOC) begin
			new_word = word | (WORD_W'(1) << low_b);
			do_write = alloc_ok;
			res_id   = alloc_ok ? cand[ID_W-1:0] : '0;
			res_st   = alloc_ok ? ST_OK : ST_FULL;
		end else begin
			new_word = word & ~(WORD_W'(1) << idm1[BIT_W-1:0]);
			do_write = !none_s1;
			res_id   = '0;
			res_st   = none_s1 ? ST_BAD_ID : ST_OK;
		end
	end

	// bitmap write back
	always_ff @(posedge clk) begin
		if (cmd.commit && do_write) begin
			mem[addr_s1] <= new_word;
		end
	end

	// full summary and written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
			vld_q  <= '0;
		end else if (cmd.commit && do_write) begin
			full_q[addr_s1] <= &new_word;
			vld_q[addr_s1]  <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			given_id_q <= res_id;
			status_q   <= res_st;
		end
	end

	assign sts.slot_free = !out_valid_q || rsp_ready;
	assign rsp_valid     = out_valid_q;
	assign rsp_given_id  = given_id_q;
	assign rsp_status    = status_q;

endmodule

// ===== hdl/association_id_allocator.sv =====
// top level of the association id allocator
//
//  channel  dir  payload             beat when
//  req      in   kind, free_id       req.valid && req.ready
//  rsp      out  given_id, status    rsp.valid && rsp.ready
//
// each request passes from its beat to its response beat through capture,
// memory read of one bitmap word, and search with bitmap write back and result register load
// a new request beat is taken only after the previous request has been committed
// the result register holds one response; a stalled rsp holds the search
// reset clears the full summary and per-word written flags, so no clearing pass
module association_id_allocator
	import aia_pkg::*;
#(
	parameter int unsigned MAP_WORDS = 64,
	parameter int unsigned MAX_ID    = 2007
) (
	input logic       clk,
	input logic       arst_n,
	aia_req_if.sink   req,
	aia_rsp_if.source rsp
);

	aia_cmd_t cmd;
	aia_sts_t sts;

	aia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	aia_dp #(
		.MAP_WORDS (MAP_WORDS),
		.MAX_ID    (MAX_ID)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_kind     (req.kind),
		.req_free_id  (req.free_id),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.rsp_given_id (rsp.given_id),
		.rsp_status   (rsp.status)
	);

endmodule

// ===== hdl/aia_chk.sv =====
// port level checks of the allocator and their binding
module aia_chk
	import aia_pkg::*;
#(
	parameter int unsigned MAX_ID = 2007
) (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input logic [ID_W-1:0] given_id,
	input status_t         status
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(given_id) && $stable(status))
		else $error("response changed while stalled");

	// only a successful allocate carries an id
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> given_id == '0)
		else $error("id on a failed or bad request");

	// an issued id is legal
	a_id_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && given_id != '0 |-> {1'b0, given_id} <= 12'(MAX_ID))
		else $error("issued id above maximum");

	// one request in work at a time
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// a request beat is not followed at once by a rising response valid
	a_rsp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("response too early");

endmodule

bind association_id_allocator aia_chk #(
	.MAX_ID (MAX_ID)
) u_aia_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.given_id  (rsp.given_id),
	.status    (rsp.status)
);

// ===== test/association_id_allocator_checker.sv =====
// checker that predicts and compares association id allocator responses
module association_id_allocator_checker
	import aia_pkg::*;
#(
	parameter int unsigned MAP_WORDS = 64,
	parameter int unsigned MAX_ID    = 2007
) (
	input  logic clk,
	input  logic arst_n,
	aia_req_if   req,
	aia_rsp_if   rsp,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ID_W-1:0] id;
		status_t         status;
	} id_grant_t;

	// one bit per association id, bit b of word w is id w*32+b+1
	logic [WORD_W-1:0] used_map [MAP_WORDS];
	id_grant_t         grant_q [$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	task automatic report(string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	// apply one request to the id map and return the response it earns
	function automatic id_grant_t serve_request(kind_t kind, logic [ID_W-1:0] fid);
		id_grant_t   res;
		int unsigned cand;
		int unsigned idx;
		int unsigned w;
		int unsigned b;
		res.id     = '0;
		res.status = ST_FULL;
		if (kind == KIND_ALLOC) begin
			// lowest clear bit of the first word that is not full
			for (int unsigned i = 0; i < MAP_WORDS; i++) begin
				if (used_map[i] != '1) begin
					b = 0;
					while (b < WORD_W && used_map[i][b])
						b++;
					cand = i * WORD_W + b + 1;
					if (cand <= MAX_ID) begin
						used_map[i][b] = 1'b1;
						res.id         = cand[ID_W-1:0];
						res.status     = ST_OK;
					end
					return res;
				end
			end
			return res;
		end
		// release: zero, above the max id or beyond the map is rejected
		res.status = ST_BAD_ID;
		idx = fid;
		if (idx != 0 && idx <= MAX_ID) begin
			w = (idx - 1) / WORD_W;
			b = (idx - 1) % WORD_W;
			if (w < MAP_WORDS) begin
				used_map[w][b] = 1'b0;
				res.status     = ST_OK;
			end
		end
		return res;
	endfunction

	// compare each response beat with the oldest prediction, then predict new requests
	always @(posedge clk or negedge arst_n) begin
		id_grant_t want;
		if (!arst_n) begin
			foreach (used_map[i])
				used_map[i] = '0;
			grant_q.delete();
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (grant_q.size() == 0) begin
					report($sformatf("response beat with nothing pending: id %0d status %0d",
						rsp.given_id, rsp.status));
				end else begin
					want = grant_q.pop_front();
					if (rsp.given_id !== want.id)
						report($sformatf("given_id mismatch: got %0d, expected %0d",
							rsp.given_id, want.id));
					if (rsp.status !== want.status)
						report($sformatf("status mismatch: got %0d, expected %0d",
							rsp.status, want.status));
				end
			end
			if (req.valid && req.ready)
				grant_q.push_back(serve_request(req.kind, req.free_id));
			pending = grant_q.size();
		end
	end

endmodule

// ===== test/association_id_allocator_tb.sv =====
// top testbench of the association id allocator: stimulus, watchdog and verdict
module association_id_allocator_tb;
	import aia_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAP_WORDS   = 64;
	localparam int unsigned MAX_ID      = 2007;
	localparam int unsigned ID_TOP      = (1 << ID_W) - 1;
	localparam int unsigned GAP_MAX     = 17;
	localparam int unsigned HOLD_AT     = 150;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned STALL_LIMIT = 3000;

	logic        clk = 1'b0;
	logic        arst_n;
	int          errors;
	int          pending;
	int unsigned sent = 0;
	int unsigned taken = 0;
	int unsigned idle_cycles = 0;
	int unsigned live_guess = 0;

	aia_req_if req ();
	aia_rsp_if rsp ();

	association_id_allocator #(
		.MAP_WORDS(MAP_WORDS),
		.MAX_ID   (MAX_ID)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	association_id_allocator_checker #(
		.MAP_WORDS(MAP_WORDS),
		.MAX_ID   (MAX_ID)
	) id_check (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.errors (errors),
		.pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// idle cycles before a beat, with stretches of back-to-back beats
	function automatic int unsigned draw_gap(int unsigned n);
		if ((n / 40) % 5 == 0)
			return 0;
		return $urandom_range(0, GAP_MAX);
	endfunction

	// drive one request beat and wait for it to be taken
	task automatic issue(kind_t kind, int unsigned fid);
		int unsigned gap;
		gap = draw_gap(sent);
		if (gap > 0) begin
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req.valid   <= 1'b1;
		req.kind    <= kind;
		req.free_id <= ID_W'(fid);
		do @(posedge clk); while (!req.ready);
		sent++;
		// rough occupancy, only used to aim releases at ids likely in use
		if (kind == KIND_ALLOC) begin
			if (live_guess < MAX_ID)
				live_guess++;
		end else if (fid != 0 && fid <= live_guess && live_guess > 0) begin
			live_guess--;
		end
	endtask

	// allocate, with a random ignored id field
	task automatic grab_id();
		issue(KIND_ALLOC, $urandom_range(0, ID_TOP));
	endtask

	task automatic drop_id(int unsigned fid);
		issue(KIND_FREE, fid);
	endtask

	// id to release: mostly ones likely held, some anywhere, some at the edges
	function automatic int unsigned pick_victim();
		int unsigned r;
		int unsigned span;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			span = live_guess + 4;
			if (span > MAX_ID)
				span = MAX_ID;
			return $urandom_range(1, span);
		end
		if (r < 90)
			return $urandom_range(0, ID_TOP);
		case (r % 4)
			0: return 0;
			1: return MAX_ID;
			2: return MAX_ID + 1;
			default: return ID_TOP;
		endcase
	endfunction

	// random mix of allocates and releases
	task automatic churn(int unsigned n, int unsigned alloc_pct);
		repeat (n) begin
			if ($urandom_range(0, 99) < alloc_pct)
				grab_id();
			else
				drop_id(pick_victim());
		end
	endtask

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("[association_id_allocator] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// response side, with one long hold-off so the block backs up
	initial begin
		int unsigned gap;
		rsp.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = (taken == HOLD_AT) ? HOLD_CYCLES : draw_gap(taken + 17);
			if (gap > 0) begin
				@(negedge clk);
				rsp.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			taken++;
		end
	end

	// request side and verdict
	initial begin
		req.valid   = 1'b0;
		req.kind    = KIND_ALLOC;
		req.free_id = '0;
		arst_n      = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// releases out of range and of ids not held
		drop_id(0);
		drop_id(ID_TOP);
		drop_id(MAX_ID + 1);
		drop_id(MAX_ID);
		drop_id(1);
		drop_id(WORD_W);
		// allocate, punch holes, refill lowest first
		repeat (5) grab_id();
		drop_id(3);
		drop_id(1);
		repeat (3) grab_id();
		drop_id(1024);
		drop_id(5);
		repeat (3) grab_id();

		// light occupancy
		churn(40, 55);

		// fill the map until allocates run past the max id
		repeat (MAX_ID + 8) grab_id();

		// top end of the id range and holes in a full map
		drop_id(MAX_ID);
		grab_id();
		grab_id();
		drop_id(MAX_ID - 22);
		drop_id(1000);
		repeat (3) grab_id();

		// heavy occupancy
		churn(60, 45);

		@(negedge clk);
		req.valid <= 1'b0;
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[association_id_allocator] OK");
		else
			$display("[association_id_allocator] ERROR");
		$finish;
	end

endmodule
